### hdl/adp_pkg.sv
// Shared types and constants for the Art-Net DMX pixel parser.
// Used by adp_div, adp_seq_store and artnet_dmx_pixel_parser; depends on nothing.
package adp_pkg;

  typedef enum logic [2:0] {
    K_PIXEL   = 3'd0,
    K_GOOD    = 3'd1,
    K_SYNC    = 3'd2,
    K_BADID   = 3'd3,
    K_OPCODE  = 3'd4,
    K_VERSION = 3'd5,
    K_RANGE   = 3'd6,
    K_SHORT   = 3'd7
  } kind_e;

  // The fault register reuses the result kinds; zero means no fault.
  localparam kind_e FAULT_NONE = K_PIXEL;

  localparam int NUM_UNIVERSES_DEF = 20;
  localparam int PIXELS_PER_UNIVERSE_DEF = 170;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIV_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd1;
  localparam logic [11:0] ROW_WIDTH_RST = 12'd16;

  // Packet byte positions.
  localparam logic [10:0] BI_ID_END = 11'd8;
  localparam logic [10:0] BI_OPC_HI = 11'd8;
  localparam logic [10:0] BI_OPC_LO = 11'd9;
  localparam logic [10:0] BI_VER_HI = 11'd10;
  localparam logic [10:0] BI_VER_LO = 11'd11;
  localparam logic [10:0] BI_SEQ = 11'd12;
  localparam logic [10:0] BI_UNIV_LO = 11'd14;
  localparam logic [10:0] BI_UNIV_HI = 11'd15;
  localparam logic [10:0] BI_LEN_HI = 11'd16;
  localparam logic [10:0] BI_LEN_LO = 11'd17;
  localparam logic [10:0] BI_DATA = 11'd18;
  localparam logic [10:0] IDX_MAX = 11'd2047;

  localparam logic [7:0] OPC_SYNC = 8'h52;
  localparam logic [7:0] OPC_DMX = 8'h50;
  localparam logic [7:0] PROTO_VER = 8'd14;
  localparam logic [8:0] GAP_LIMIT = 9'h0E0;

  // Divider widths: start position over row width.
  localparam int DIV_N = 16;
  localparam int DIV_D = 12;

  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'h41;
      3'd1: v = 8'h72;
      3'd2: v = 8'h74;
      3'd3: v = 8'h2D;
      3'd4: v = 8'h4E;
      3'd5: v = 8'h65;
      3'd6: v = 8'h74;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### hdl/adp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on adp_pkg for its widths.
module adp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [adp_pkg::DIV_N-1:0] dividend_i,
  input  logic [adp_pkg::DIV_D-1:0] divisor_i,
  output logic                      done_o,
  output logic [adp_pkg::DIV_N-1:0] quotient_o,
  output logic [adp_pkg::DIV_D-1:0] remainder_o
);
  import adp_pkg::*;

  localparam int CNT_W = $clog2(DIV_N);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_N-1:0] quo_q, quo_d;
  logic [DIV_D-1:0] rem_q, rem_d;
  logic [DIV_D-1:0] div_q, div_d;
  logic [DIV_D:0]   trial;
  logic [DIV_D:0]   diff;

  assign trial = {rem_q, quo_q[DIV_N-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits the divisor width.
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[DIV_D-1:0];
        quo_d = {quo_q[DIV_N-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_D-1:0];
        quo_d = {quo_q[DIV_N-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### hdl/adp_seq_store.sv
// Per-universe store of the last sequence number, with a valid flag per entry.
// Memory with registered read; valid flags cleared by reset. Uses adp_pkg.
module adp_seq_store #(
  parameter int NUM_UNIVERSES = adp_pkg::NUM_UNIVERSES_DEF,
  parameter int UIDX_W = (NUM_UNIVERSES > 1) ? $clog2(NUM_UNIVERSES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [UIDX_W-1:0] rd_addr_i,
  output logic              rd_valid_o,
  output logic [7:0]        rd_seq_o,
  input  logic              wr_en_i,
  input  logic [UIDX_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_seq_i
);
  import adp_pkg::*;

  logic [7:0]               mem_q [NUM_UNIVERSES];
  logic [NUM_UNIVERSES-1:0] vld_q;
  logic                     rd_valid_q;
  logic [7:0]               rd_seq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= vld_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_seq_i;
    end
    rd_seq_q <= mem_q[rd_addr_i];
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_seq_o   = rd_seq_q;

endmodule

### hdl/artnet_dmx_pixel_parser.sv
// Top level of the Art-Net DMX pixel parser: byte sequencer, output register.
// Instantiates adp_seq_store and adp_div; uses adp_pkg.
//
// Usage: packet bytes enter on the s_axis channel, one byte per beat, with
// s_axis_tlast_i on the final byte. Results leave on m_axis: tuser is the
// kind, tdata the pixel position, color levels and lost count, tlast marks
// the status beat that closes each packet. The cfg channel writes the
// universe offset (index 0) and the row width (index 1); it is always ready.
// Flow: bytes are taken back to back; a byte that completes a pixel and ends
// the packet holds the input while its status follows the pixel out. Byte 17
// of an ArtDmx packet with a valid universe holds the input while the store
// is read and the start multiplied, the divider is launched, steps through
// its quotient bits and raises its done flag (only the first if it ends there).
// A result is registered into the output register as the byte that causes it
// is taken, a status on byte 17 from S_RD. When the receiver stalls,
// the result holds and the byte input stops taking beats until it frees.
// Reset clears all per-packet state and marks every universe entry unseen;
// the offset returns to 0 and the row width to 16.
module artnet_dmx_pixel_parser #(
  parameter int NUM_UNIVERSES = adp_pkg::NUM_UNIVERSES_DEF,
  parameter int PIXELS_PER_UNIVERSE = adp_pkg::PIXELS_PER_UNIVERSE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // data_byte
  input  logic                          s_axis_tlast_i,  // end_of_packet
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // pixel_x[11:0], pixel_y[23:12], red[31:24], green[39:32], blue[47:40],
  // lost_packets[55:48]
  output logic [55:0]                   m_axis_tdata_o,
  output logic [2:0]                    m_axis_tuser_o,  // kind
  output logic                          m_axis_tlast_o,  // last
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [adp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import adp_pkg::*;

  localparam int UIDX_W = (NUM_UNIVERSES > 1) ? $clog2(NUM_UNIVERSES) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RD    = 4'b0010,
    S_DIVGO = 4'b0100,
    S_DIV   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] univ_off_q, univ_off_d;
  logic [11:0] row_width_q, row_width_d;

  logic [10:0] byte_idx_q, byte_idx_d;
  kind_e       fault_q, fault_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] univ_q, univ_d;
  logic [15:0] len_q, len_d;
  logic [11:0] cx_q, cx_d;
  logic [11:0] cy_q, cy_d;
  logic [15:0] triple_q, triple_d;
  logic [7:0]  lost_q, lost_d;
  logic [1:0]  ph_q, ph_d;
  logic [10:0] tstart_q, tstart_d;
  logic        eop_pend_q, eop_pend_d;
  logic [15:0] start_q, start_d;

  logic        ov_q, ov_d;
  kind_e       okind_q, okind_d;
  logic [11:0] ox_q, ox_d;
  logic [11:0] oy_q, oy_d;
  logic [7:0]  ored_q, ored_d;
  logic [7:0]  ogrn_q, ogrn_d;
  logic [7:0]  oblu_q, oblu_d;
  logic [7:0]  olost_q, olost_d;
  logic        olast_q, olast_d;

  logic        spend_q, spend_d;
  kind_e       skind_q, skind_d;
  logic [7:0]  slost_q, slost_d;

  logic [15:0]       u16;
  logic              u_in_range;
  logic [UIDX_W-1:0] u_idx;
  logic [11:0]       w_eff;
  logic              accept;
  logic              st_valid;
  logic [7:0]        st_seq;
  logic              st_wr;
  logic [8:0]        gap;
  logic [7:0]        gap_lost;
  logic [31:0]       prod;
  logic              div_start;
  logic              div_done;
  logic [15:0]       div_quo;
  logic [11:0]       div_rem;

  assign u16        = univ_q - univ_off_q;
  assign u_in_range = u16 < 16'(NUM_UNIVERSES);
  assign u_idx      = u16[UIDX_W-1:0];
  assign w_eff      = (row_width_q == 12'd0) ? 12'd1 : row_width_q;
  assign prod       = 32'(u_idx) * 32'(PIXELS_PER_UNIVERSE);

  assign s_axis_tready_o = (state_q == S_IDLE) && !spend_q && (!ov_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // A gap is counted only when the new number lies 2 to 223 ahead.
  assign gap      = {1'b0, seq_q} - {1'b0, st_seq};
  assign gap_lost = (st_valid && !gap[8] && gap > 9'd1 && gap < GAP_LIMIT) ?
                    (gap[7:0] - 8'd1) : 8'd0;
  assign st_wr    = (state_q == S_RD);

  adp_seq_store #(
    .NUM_UNIVERSES(NUM_UNIVERSES),
    .UIDX_W       (UIDX_W)
  ) u_seq_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (u_idx),
    .rd_valid_o(st_valid),
    .rd_seq_o  (st_seq),
    .wr_en_i   (st_wr),
    .wr_addr_i (u_idx),
    .wr_seq_i  (seq_q)
  );

  adp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (start_q),
    .divisor_i  (w_eff),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    univ_off_d  = univ_off_q;
    row_width_d = row_width_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_UNIV_OFFSET: univ_off_d = cfg_data_i;
        CFG_ROW_WIDTH:   row_width_d = cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic        pix;
    logic        hdr_go;
    logic        clear;
    kind_e       st_kind;
    logic [7:0]  st_lost;
    logic [7:0]  b;
    logic [10:0] i;
    logic [12:0] cx_inc;

    pix     = 1'b0;
    hdr_go  = 1'b0;
    clear   = 1'b0;
    st_kind = K_GOOD;
    st_lost = 8'd0;
    b       = s_axis_tdata_i;
    i       = byte_idx_q;
    cx_inc  = {1'b0, cx_q} + 13'd1;

    state_d    = state_q;
    byte_idx_d = byte_idx_q;
    fault_d    = fault_q;
    seq_d      = seq_q;
    univ_d     = univ_q;
    len_d      = len_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    triple_d   = triple_q;
    lost_d     = lost_q;
    ph_d       = ph_q;
    tstart_d   = tstart_q;
    eop_pend_d = eop_pend_q;
    start_d    = start_q;
    div_start  = 1'b0;

    ov_d    = ov_q;
    okind_d = okind_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    ored_d  = ored_q;
    ogrn_d  = ogrn_q;
    oblu_d  = oblu_q;
    olost_d = olost_q;
    olast_d = olast_q;
    spend_d = spend_q;
    skind_d = skind_q;
    slost_d = slost_q;

    // Drain the output register; a held-back status goes out next.
    if (ov_q && m_axis_tready_i) begin
      if (spend_q) begin
        okind_d = skind_q;
        ox_d    = 12'd0;
        oy_d    = 12'd0;
        ored_d  = 8'd0;
        ogrn_d  = 8'd0;
        oblu_d  = 8'd0;
        olost_d = slost_q;
        olast_d = 1'b1;
        spend_d = 1'b0;
      end else begin
        ov_d = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (fault_q == FAULT_NONE && i != IDX_MAX) begin
            if (i < BI_ID_END) begin
              if (b != id_byte(i[2:0])) fault_d = K_BADID;
            end else if (i == BI_OPC_HI) begin
              if (b != 8'd0) fault_d = K_OPCODE;
            end else if (i == BI_OPC_LO) begin
              if (b == OPC_SYNC) fault_d = K_SYNC;
              else if (b != OPC_DMX) fault_d = K_OPCODE;
            end else if (i == BI_VER_HI) begin
              if (b != 8'd0) fault_d = K_VERSION;
            end else if (i == BI_VER_LO) begin
              if (b != PROTO_VER) fault_d = K_VERSION;
            end else if (i == BI_SEQ) begin
              seq_d = b;
            end else if (i == BI_UNIV_LO) begin
              univ_d = {univ_q[15:8], b};
            end else if (i == BI_UNIV_HI) begin
              univ_d = {b, univ_q[7:0]};
            end else if (i == BI_LEN_HI) begin
              len_d = {b, 8'd0};
            end else if (i == BI_LEN_LO) begin
              len_d = {len_q[15:8], b};
              if (u_in_range) hdr_go = 1'b1;
              else fault_d = K_RANGE;
            end else if (i >= BI_DATA) begin
              // Only whole triples inside the declared length produce pixels.
              if ((16'(tstart_q) + 16'd3) <= len_q) begin
                if (ph_q == 2'd0) begin
                  triple_d = {8'd0, b};
                end else if (ph_q == 2'd1) begin
                  triple_d = {b, triple_q[7:0]};
                end else begin
                  pix = 1'b1;
                  if (cx_inc >= {1'b0, w_eff}) begin
                    cx_d = 12'd0;
                    cy_d = cy_q + 12'd1;
                  end else begin
                    cx_d = cx_inc[11:0];
                  end
                end
              end
              if (ph_q == 2'd2) begin
                ph_d     = 2'd0;
                tstart_d = tstart_q + 11'd3;
              end else begin
                ph_d = ph_q + 2'd1;
              end
            end
          end
          if (i != IDX_MAX) byte_idx_d = i + 11'd1;

          if (pix) begin
            ov_d    = 1'b1;
            okind_d = K_PIXEL;
            ox_d    = cx_q;
            oy_d    = cy_q;
            ored_d  = triple_q[15:8];
            ogrn_d  = triple_q[7:0];
            oblu_d  = b;
            olost_d = 8'd0;
            olast_d = 1'b0;
          end

          if (fault_d != FAULT_NONE) begin
            st_kind = fault_d;
          end else if (i < BI_LEN_LO) begin
            st_kind = K_SHORT;
          end else begin
            st_kind = K_GOOD;
            st_lost = lost_q;
          end

          if (hdr_go) begin
            // The status of a packet ending here waits for the gap check.
            eop_pend_d = s_axis_tlast_i;
            state_d    = S_RD;
          end else if (s_axis_tlast_i) begin
            clear = 1'b1;
            if (pix) begin
              spend_d = 1'b1;
              skind_d = st_kind;
              slost_d = st_lost;
            end else begin
              ov_d    = 1'b1;
              okind_d = st_kind;
              ox_d    = 12'd0;
              oy_d    = 12'd0;
              ored_d  = 8'd0;
              ogrn_d  = 8'd0;
              oblu_d  = 8'd0;
              olost_d = st_lost;
              olast_d = 1'b1;
            end
          end
        end
      end
      S_RD: begin
        start_d = prod[15:0];
        if (eop_pend_q) begin
          clear      = 1'b1;
          eop_pend_d = 1'b0;
          ov_d       = 1'b1;
          okind_d    = K_GOOD;
          ox_d       = 12'd0;
          oy_d       = 12'd0;
          ored_d     = 8'd0;
          ogrn_d     = 8'd0;
          oblu_d     = 8'd0;
          olost_d    = gap_lost;
          olast_d    = 1'b1;
          state_d    = S_IDLE;
        end else begin
          lost_d  = gap_lost;
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          cx_d    = div_rem;
          cy_d    = div_quo[11:0];
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (clear) begin
      byte_idx_d = 11'd0;
      fault_d    = FAULT_NONE;
      seq_d      = 8'd0;
      univ_d     = 16'd0;
      len_d      = 16'd0;
      cx_d       = 12'd0;
      cy_d       = 12'd0;
      triple_d   = 16'd0;
      lost_d     = 8'd0;
      ph_d       = 2'd0;
      tstart_d   = 11'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      univ_off_q  <= 16'd0;
      row_width_q <= ROW_WIDTH_RST;
      byte_idx_q  <= 11'd0;
      fault_q     <= FAULT_NONE;
      seq_q       <= 8'd0;
      univ_q      <= 16'd0;
      len_q       <= 16'd0;
      cx_q        <= 12'd0;
      cy_q        <= 12'd0;
      triple_q    <= 16'd0;
      lost_q      <= 8'd0;
      ph_q        <= 2'd0;
      tstart_q    <= 11'd0;
      eop_pend_q  <= 1'b0;
      ov_q        <= 1'b0;
      spend_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      univ_off_q  <= univ_off_d;
      row_width_q <= row_width_d;
      byte_idx_q  <= byte_idx_d;
      fault_q     <= fault_d;
      seq_q       <= seq_d;
      univ_q      <= univ_d;
      len_q       <= len_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      triple_q    <= triple_d;
      lost_q      <= lost_d;
      ph_q        <= ph_d;
      tstart_q    <= tstart_d;
      eop_pend_q  <= eop_pend_d;
      ov_q        <= ov_d;
      spend_q     <= spend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    okind_q <= okind_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    ored_q  <= ored_d;
    ogrn_q  <= ogrn_d;
    oblu_q  <= oblu_d;
    olost_q <= olost_d;
    olast_q <= olast_d;
    skind_q <= skind_d;
    slost_q <= slost_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {olost_q, oblu_q, ogrn_q, ored_q, oy_q, ox_q};
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;

endmodule
